@@ hdl/vector_clock_unit_defines.svh @@
// assertion macros used by the vector clock unit back end
`ifndef VECTOR_CLOCK_UNIT_DEFINES_SVH
`define VECTOR_CLOCK_UNIT_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define VCU_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vector clock unit check failed");

// next-cycle implication
`define VCU_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vector clock unit sequence check failed");

`endif

@@ hdl/vcu_pkg.sv @@
// shared types and constants of the vector clock unit
package vcu_pkg;

   localparam int IDX_W   = 4;
   localparam int VAL_W   = 32;
   localparam int CNT_W   = 5;
   localparam int OWN_W   = 4;
   localparam int REL_W   = 3;

   // configuration register indexes
   localparam logic CSR_OWN_ID     = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_MERGE   = 2'd1,
      OP_COMPARE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [REL_W-1:0] {
      REL_EQUAL      = 3'd0,
      REL_BEFORE     = 3'd1,
      REL_AFTER      = 3'd2,
      REL_CONCURRENT = 3'd3,
      REL_SIZE       = 3'd4
   } rel_type;

   // classified item handed from the front end to the back end
   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   idx;
      logic [VAL_W-1:0]   value;
      logic               last;
      logic [OWN_W-1:0]   own_id;
      logic               need_bump;
      logic               own_in_bank;
      logic               hit;
      logic               in_bank;
      logic               size_mismatch;
   } cmd_type;

endpackage

@@ hdl/vector_clock_unit.sv @@
// items are buffered in a two-word queue and then worked one at a time by a
// read-modify-write sequence on the counter ram (one write port, one read port,
// registered read); a tick, and the first item of a merge run, bump the own entry
// first, and the back end holds its result while the response output is stalled
// reset: own_id 0, node_count 16, all entries read zero through per-entry valid bits,
// no clearing pass; runs and compare flags start empty
module vector_clock_unit
   import vcu_pkg::*;
#(
   parameter int MAX_NODES   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CNT_W-1:0] csr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,   // element_index, element_value, other_count
   input  logic [1:0]       req_tuser,   // opcode
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,   // entry_value, relation
   output logic             rsp_tuser    // is_compare
);

   logic             q_full, q_push, q_pop, q_valid;
   cmd_type          push_cmd, head_cmd;
   logic [VAL_W-1:0] entry_value;
   logic [REL_W-1:0] relation;

   vcu_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_opcode        (req_tuser),
      .req_element_index (req_tdata[3:0]),
      .req_element_value (req_tdata[35:4]),
      .req_last_element  (req_tlast),
      .req_other_count   (req_tdata[40:36]),
      .q_full            (q_full),
      .push              (q_push),
      .cmd               (push_cmd)
   );

   vcu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   vcu_back #(
      .MAX_NODES   (MAX_NODES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .entry_value (entry_value),
      .relation    (relation),
      .is_compare  (rsp_tuser)
   );

   assign rsp_tdata = {5'b0, relation, entry_value};

endmodule

@@ hdl/vcu_ram.sv @@
// generic single write port, single read port ram with registered read
module vcu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/vcu_front.sv @@
// front end: config registers, input acceptance and item classification
module vcu_front
   import vcu_pkg::*;
#(
   parameter int MAX_NODES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CNT_W-1:0] csr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_opcode,
   input  logic [IDX_W-1:0] req_element_index,
   input  logic [VAL_W-1:0] req_element_value,
   input  logic             req_last_element,
   input  logic [CNT_W-1:0] req_other_count,
   input  logic             q_full,
   output logic             push,
   output cmd_type          cmd
);

   logic [OWN_W-1:0] own_id_ff, own_id_in;
   logic [CNT_W-1:0] node_count_ff, node_count_in;
   logic             merge_in_run_ff, merge_in_run_in;
   logic [31:0]      used_cnt;
   logic [31:0]      idx_ext;
   op_type           op;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;
   assign op        = op_type'(req_opcode);
   assign idx_ext   = 32'(req_element_index);

   // entries in use, saturated at the bank size
   assign used_cnt = (32'(node_count_ff) > 32'(MAX_NODES)) ? 32'(MAX_NODES)
                                                          : 32'(node_count_ff);

   always_comb begin
      cmd.op            = op;
      cmd.idx           = req_element_index;
      cmd.value         = req_element_value;
      cmd.last          = req_last_element;
      cmd.own_id        = own_id_ff;
      cmd.need_bump     = (op == OP_TICK) || ((op == OP_MERGE) && !merge_in_run_ff);
      cmd.own_in_bank   = 32'(own_id_ff) < 32'(MAX_NODES);
      cmd.hit           = idx_ext < used_cnt;
      cmd.in_bank       = idx_ext < 32'(MAX_NODES);
      cmd.size_mismatch = 32'(req_other_count) != used_cnt;
   end

   always_comb begin
      own_id_in       = own_id_ff;
      node_count_in   = node_count_ff;
      merge_in_run_in = merge_in_run_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ID:     own_id_in     = csr_data[OWN_W-1:0];
            CSR_NODE_COUNT: node_count_in = csr_data;
            default:        own_id_in     = own_id_ff;
         endcase
      end
      if (push && (op == OP_MERGE)) begin
         merge_in_run_in = !req_last_element;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff       <= '0;
         node_count_ff   <= CNT_W'(16);
         merge_in_run_ff <= 1'b0;
      end else begin
         own_id_ff       <= own_id_in;
         node_count_ff   <= node_count_in;
         merge_in_run_ff <= merge_in_run_in;
      end
   end

endmodule

@@ hdl/vcu_queue.sv @@
// two-word queue between the front end and the back end
module vcu_queue
   import vcu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_QW = $clog2(DEPTH + 1);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = count_ff == CNT_QW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/vcu_back.sv @@
// back end: counter bank sequencer, compare flags and result register
`include "vector_clock_unit_defines.svh"

module vcu_back
   import vcu_pkg::*;
#(
   parameter int MAX_NODES   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] entry_value,
   output logic [REL_W-1:0] relation,
   output logic             is_compare
);

   localparam int AW = $clog2(MAX_NODES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BUMP,
      S_ELEM_RD,
      S_ELEM,
      S_RESULT
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [MAX_NODES-1:0]   valid_ff, valid_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   all_not_greater_ff, all_not_greater_in;
   logic                   all_not_less_ff, all_not_less_in;
   logic                   some_less_ff, some_less_in;
   logic                   some_greater_ff, some_greater_in;
   logic [VAL_W-1:0]       pend_value_ff, pend_value_in;
   rel_type                pend_rel_ff, pend_rel_in;
   logic                   pend_cmp_ff, pend_cmp_in;
   logic                   res_valid_ff, res_valid_in;
   logic [VAL_W-1:0]       res_value_ff, res_value_in;
   rel_type                res_rel_ff, res_rel_in;
   logic                   res_cmp_ff, res_cmp_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [COUNT_WIDTH-1:0] ram_wr_data, ram_rd_data;
   logic [COUNT_WIDTH-1:0] old_cnt, elem_cnt, bumped;
   logic                   out_free;
   logic                   nf_ang, nf_anl, nf_sl, nf_sg;

   vcu_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_NODES)
   ) u_bank (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // entries never written since reset read as zero
   assign old_cnt  = rd_valid_ff ? ram_rd_data : '0;
   assign elem_cnt = COUNT_WIDTH'(cmd_ff.value);
   assign bumped   = old_cnt + 1'b1;
   assign out_free = !res_valid_ff || rsp_ready;

   // compare flags including the element under work
   always_comb begin
      nf_ang = all_not_greater_ff;
      nf_anl = all_not_less_ff;
      nf_sl  = some_less_ff;
      nf_sg  = some_greater_ff;
      if (cmd_ff.hit) begin
         if (old_cnt > elem_cnt) begin
            nf_ang = 1'b0;
            nf_sg  = 1'b1;
         end else if (old_cnt < elem_cnt) begin
            nf_anl = 1'b0;
            nf_sl  = 1'b1;
         end
      end
   end

   always_comb begin
      state_in           = state_ff;
      cmd_in             = cmd_ff;
      valid_in           = valid_ff;
      rd_valid_in        = rd_valid_ff;
      all_not_greater_in = all_not_greater_ff;
      all_not_less_in    = all_not_less_ff;
      some_less_in       = some_less_ff;
      some_greater_in    = some_greater_ff;
      pend_value_in      = pend_value_ff;
      pend_rel_in        = pend_rel_ff;
      pend_cmp_in        = pend_cmp_ff;
      res_valid_in       = res_valid_ff && !rsp_ready;
      res_value_in       = res_value_ff;
      res_rel_in         = res_rel_ff;
      res_cmp_in         = res_cmp_ff;
      q_pop              = 1'b0;
      ram_rd_en          = 1'b0;
      ram_rd_addr        = AW'(q_cmd.idx);
      ram_wr_en          = 1'b0;
      ram_wr_addr        = AW'(cmd_ff.own_id);
      ram_wr_data        = bumped;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               pend_value_in = '0;
               pend_rel_in   = REL_EQUAL;
               pend_cmp_in   = 1'b0;
               if (q_cmd.need_bump && q_cmd.own_in_bank) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(q_cmd.own_id);
                  state_in    = S_BUMP;
               end else if (q_cmd.op == OP_TICK) begin
                  state_in = S_RESULT;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = S_ELEM;
               end
            end
         end
         S_BUMP: begin
            ram_wr_en = 1'b1;
            if (cmd_ff.op == OP_TICK) begin
               pend_value_in = VAL_W'(bumped);
               state_in      = S_RESULT;
            end else begin
               state_in = S_ELEM_RD;
            end
         end
         S_ELEM_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(cmd_ff.idx);
            state_in    = S_ELEM;
         end
         S_ELEM: begin
            ram_wr_addr = AW'(cmd_ff.idx);
            ram_wr_data = elem_cnt;
            unique case (cmd_ff.op)
               OP_MERGE: begin
                  if (cmd_ff.hit) begin
                     ram_wr_en     = old_cnt < elem_cnt;
                     pend_value_in = (old_cnt < elem_cnt) ? VAL_W'(elem_cnt)
                                                          : VAL_W'(old_cnt);
                  end
                  state_in = S_RESULT;
               end
               OP_COMPARE: begin
                  if (cmd_ff.last) begin
                     priority if (cmd_ff.size_mismatch) begin
                        pend_rel_in = REL_SIZE;
                     end else if (!nf_sl && !nf_sg) begin
                        pend_rel_in = REL_EQUAL;
                     end else if (nf_sl && nf_ang) begin
                        pend_rel_in = REL_BEFORE;
                     end else if (nf_sg && nf_anl) begin
                        pend_rel_in = REL_AFTER;
                     end else begin
                        pend_rel_in = REL_CONCURRENT;
                     end
                     pend_cmp_in        = 1'b1;
                     all_not_greater_in = 1'b1;
                     all_not_less_in    = 1'b1;
                     some_less_in       = 1'b0;
                     some_greater_in    = 1'b0;
                     state_in           = S_RESULT;
                  end else begin
                     all_not_greater_in = nf_ang;
                     all_not_less_in    = nf_anl;
                     some_less_in       = nf_sl;
                     some_greater_in    = nf_sg;
                     state_in           = S_IDLE;
                  end
               end
               OP_READ: begin
                  pend_value_in = cmd_ff.in_bank ? VAL_W'(old_cnt) : '0;
                  state_in      = S_RESULT;
               end
               OP_TICK: begin
                  state_in = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RESULT: begin
            if (out_free) begin
               res_valid_in = 1'b1;
               res_value_in = pend_value_ff;
               res_rel_in   = pend_rel_ff;
               res_cmp_in   = pend_cmp_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ram_rd_en) begin
         rd_valid_in = valid_ff[ram_rd_addr];
      end
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         valid_ff           <= '0;
         rd_valid_ff        <= 1'b0;
         all_not_greater_ff <= 1'b1;
         all_not_less_ff    <= 1'b1;
         some_less_ff       <= 1'b0;
         some_greater_ff    <= 1'b0;
         res_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         valid_ff           <= valid_in;
         rd_valid_ff        <= rd_valid_in;
         all_not_greater_ff <= all_not_greater_in;
         all_not_less_ff    <= all_not_less_in;
         some_less_ff       <= some_less_in;
         some_greater_ff    <= some_greater_in;
         res_valid_ff       <= res_valid_in;
      end
      cmd_ff        <= cmd_in;
      pend_value_ff <= pend_value_in;
      pend_rel_ff   <= pend_rel_in;
      pend_cmp_ff   <= pend_cmp_in;
      res_value_ff  <= res_value_in;
      res_rel_ff    <= res_rel_in;
      res_cmp_ff    <= res_cmp_in;
   end

   assign rsp_valid   = res_valid_ff;
   assign entry_value = res_value_ff;
   assign relation    = res_rel_ff;
   assign is_compare  = res_cmp_ff;

   `VCU_CHECK(a_less_flags, some_less_ff, !all_not_less_ff)
   `VCU_CHECK(a_greater_flags, some_greater_ff, !all_not_greater_ff)
   `VCU_CHECK_NEXT(a_bump_next, state_ff == S_BUMP, state_ff == S_RESULT || state_ff == S_ELEM_RD)
   `VCU_CHECK_NEXT(a_result_load, state_ff == S_RESULT && out_free, res_valid_ff)

endmodule
